[sv/lbd_pkg.sv]
package lbd_pkg;

	localparam int unsigned MAX_SPAN     = 512;
	localparam int unsigned HEADER_BYTES = 12;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned CFG_DATA_W   = 32;
	localparam int unsigned POS_W        = 17;
	localparam int unsigned COUNT_W      = 10;

	localparam logic [7:0] FORMAT_ONE  = 8'h01;
	localparam logic [7:0] FLAG_COUNTS = 8'h01;

	localparam logic [POS_W-1:0]   POS_MAX   = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DAY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DAY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN   = 2'd3;

	// verdict codes
	localparam logic [2:0] ERR_OK     = 3'd0;
	localparam logic [2:0] ERR_SHORT  = 3'd1;
	localparam logic [2:0] ERR_FORMAT = 3'd2;
	localparam logic [2:0] ERR_SPAN   = 3'd3;
	localparam logic [2:0] ERR_LENGTH = 3'd4;
	localparam logic [2:0] ERR_DAY    = 3'd5;
	localparam logic [2:0] ERR_LEVEL  = 3'd6;

	typedef struct packed {
		logic signed [31:0] min_day;
		logic signed [31:0] max_day;
		logic [7:0]         level_max;
		logic [7:0]         unknown_level;
	} cfg_t;

	// blob state with the current byte already folded in
	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic [7:0]         fmt;
		logic [7:0]         flags;
		logic [31:0]        first;
		logic [15:0]        span;
		logic [31:0]        total;
		logic [COUNT_W-1:0] known;
		logic               bad;
		logic               lvl_present;
		logic [8:0]         day_idx;
	} blob_stat_t;

	typedef struct packed {
		logic               level_present;
		logic [7:0]         level;
		logic [8:0]         day_index;
		logic               done_res;
		logic               accepted;
		logic [2:0]         error_code;
		logic signed [31:0] start_day;
		logic [9:0]         span;
		logic [31:0]        total;
		logic               counts_flag;
		logic [9:0]         filled;
	} res_t;

endpackage

[sv/lbd_if.sv]
interface lbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] blob_byte;
	logic       is_last;

	modport source (output valid, output blob_byte, output is_last, input ready);
	modport sink (input valid, input blob_byte, input is_last, output ready);
endinterface

interface lbd_out_if;
	logic               valid;
	logic               ready;
	logic               level_present;
	logic [7:0]         level;
	logic [8:0]         day_index;
	logic               done_res;
	logic               accepted;
	logic [2:0]         error_code;
	logic signed [31:0] start_day;
	logic [9:0]         span;
	logic [31:0]        total;
	logic               counts_flag;
	logic [9:0]         filled;

	modport source (
		output valid, output level_present, output level, output day_index,
		output done_res, output accepted, output error_code, output start_day,
		output span, output total, output counts_flag, output filled,
		input ready
	);
	modport sink (
		input valid, input level_present, input level, input day_index,
		input done_res, input accepted, input error_code, input start_day,
		input span, input total, input counts_flag, input filled,
		output ready
	);
endinterface

[sv/lbd_cfg.sv]
module lbd_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             we,
	input  logic [lbd_pkg::CFG_IDX_W-1:0]    idx,
	input  logic [lbd_pkg::CFG_DATA_W-1:0]   wdata,
	output lbd_pkg::cfg_t                    cfg
);
	import lbd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_day       <= '0;
			cfg_q.max_day       <= '0;
			cfg_q.level_max     <= 8'd4;
			cfg_q.unknown_level <= 8'd255;
		end else if (we) begin
			case (idx)
				REG_MIN_DAY:   cfg_q.min_day       <= wdata;
				REG_MAX_DAY:   cfg_q.max_day       <= wdata;
				REG_LEVEL_MAX: cfg_q.level_max     <= wdata[7:0];
				REG_UNKNOWN:   cfg_q.unknown_level <= wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/lbd_hdr.sv]
module lbd_hdr (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic [7:0]              blob_byte,
	input  logic                    is_last,
	input  lbd_pkg::cfg_t           cfg,
	output lbd_pkg::blob_stat_t     stat
);
	import lbd_pkg::*;

	logic [POS_W-1:0]   pos_q;
	logic [7:0]         fmt_q;
	logic [7:0]         flags_q;
	logic [31:0]        first_q;
	logic [15:0]        span_q;
	logic [31:0]        total_q;
	logic [COUNT_W-1:0] known_q;
	logic               bad_q;

	logic [POS_W-1:0] idx;
	logic             in_body;
	logic             lvl;
	logic             is_unknown;

	assign idx        = pos_q - POS_W'(HEADER_BYTES);
	assign in_body    = pos_q >= POS_W'(HEADER_BYTES);
	assign lvl        = in_body && (idx < {1'b0, span_q}) && (idx < POS_W'(MAX_SPAN));
	assign is_unknown = blob_byte == cfg.unknown_level;

	always_comb begin
		stat             = '0;
		stat.pos         = pos_q;
		stat.fmt         = fmt_q;
		stat.flags       = flags_q;
		stat.first       = first_q;
		stat.span        = span_q;
		stat.total       = total_q;
		stat.known       = known_q;
		stat.bad         = bad_q;
		stat.lvl_present = lvl;
		stat.day_idx     = lvl ? idx[8:0] : 9'd0;
		case (pos_q)
			POS_W'(0):  stat.fmt          = blob_byte;
			POS_W'(1):  stat.flags        = blob_byte;
			POS_W'(2):  stat.first[7:0]   = first_q[7:0]   | blob_byte;
			POS_W'(3):  stat.first[15:8]  = first_q[15:8]  | blob_byte;
			POS_W'(4):  stat.first[23:16] = first_q[23:16] | blob_byte;
			POS_W'(5):  stat.first[31:24] = first_q[31:24] | blob_byte;
			POS_W'(6):  stat.span[7:0]    = span_q[7:0]    | blob_byte;
			POS_W'(7):  stat.span[15:8]   = span_q[15:8]   | blob_byte;
			POS_W'(8):  stat.total[7:0]   = total_q[7:0]   | blob_byte;
			POS_W'(9):  stat.total[15:8]  = total_q[15:8]  | blob_byte;
			POS_W'(10): stat.total[23:16] = total_q[23:16] | blob_byte;
			POS_W'(11): stat.total[31:24] = total_q[31:24] | blob_byte;
			default: ;
		endcase
		if (lvl) begin
			if (blob_byte > cfg.level_max && !is_unknown) stat.bad = 1'b1;
			if (!is_unknown && known_q != COUNT_MAX) stat.known = known_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			fmt_q   <= '0;
			flags_q <= '0;
			first_q <= '0;
			span_q  <= '0;
			total_q <= '0;
			known_q <= '0;
			bad_q   <= 1'b0;
		end else if (take) begin
			if (is_last) begin
				pos_q   <= '0;
				fmt_q   <= '0;
				flags_q <= '0;
				first_q <= '0;
				span_q  <= '0;
				total_q <= '0;
				known_q <= '0;
				bad_q   <= 1'b0;
			end else begin
				if (pos_q != POS_MAX) pos_q <= pos_q + 1'b1;
				fmt_q   <= stat.fmt;
				flags_q <= stat.flags;
				first_q <= stat.first;
				span_q  <= stat.span;
				total_q <= stat.total;
				known_q <= stat.known;
				bad_q   <= stat.bad;
			end
		end
	end

endmodule

[sv/lbd_judge.sv]
module lbd_judge (
	input  lbd_pkg::blob_stat_t stat,
	input  logic [7:0]          blob_byte,
	input  logic                is_last,
	input  lbd_pkg::cfg_t       cfg,
	output lbd_pkg::res_t       res
);
	import lbd_pkg::*;

	logic               short_err;
	logic               fmt_err;
	logic               span_err;
	logic               len_err;
	logic               day_err;
	logic signed [32:0] first_x;
	logic signed [32:0] last_day;
	logic signed [32:0] lo_x;
	logic signed [32:0] hi_x;
	logic [2:0]         code;

	assign short_err = stat.pos < POS_W'(HEADER_BYTES - 1);
	assign fmt_err   = (stat.fmt != FORMAT_ONE) || ((stat.flags & ~FLAG_COUNTS) != 8'd0);
	assign span_err  = (stat.span == 16'd0) || ({1'b0, stat.span} > POS_W'(MAX_SPAN));
	assign len_err   = stat.pos != (POS_W'(HEADER_BYTES - 1) + {1'b0, stat.span});

	assign first_x  = {stat.first[31], stat.first};
	assign lo_x     = {cfg.min_day[31], cfg.min_day};
	assign hi_x     = {cfg.max_day[31], cfg.max_day};
	// span is at most MAX_SPAN here, so 33 bits hold the last covered day
	assign last_day = first_x + $signed({17'd0, stat.span}) - 33'sd1;
	assign day_err  = (first_x < lo_x) || (first_x > hi_x) || (last_day > hi_x);

	always_comb begin
		if (short_err)     code = ERR_SHORT;
		else if (fmt_err)  code = ERR_FORMAT;
		else if (span_err) code = ERR_SPAN;
		else if (len_err)  code = ERR_LENGTH;
		else if (day_err)  code = ERR_DAY;
		else if (stat.bad) code = ERR_LEVEL;
		else               code = ERR_OK;
	end

	always_comb begin
		res               = '0;
		res.level_present = stat.lvl_present;
		res.level         = stat.lvl_present ? blob_byte : 8'd0;
		res.day_index     = stat.day_idx;
		if (is_last) begin
			res.done_res   = 1'b1;
			res.error_code = code;
			if (code == ERR_OK) begin
				res.accepted    = 1'b1;
				res.start_day   = stat.first;
				res.span        = stat.span[9:0];
				res.total       = stat.total;
				res.counts_flag = stat.flags[0];
				res.filled      = stat.known;
			end
		end
	end

endmodule

[sv/level_blob_decoder.sv]
// channel   dir  payload                                      handshake
// blob_in   in   blob_byte, is_last                           valid/ready
// res_out   out  level_present .. filled (one per item)       valid/ready
// cfg       in   cfg_we, cfg_idx, cfg_wdata                   write on cfg_we
//
// one item per cycle while res_out is not stalled; its result is registered and appears in the cycle after acceptance
// the result register holds while res_out stalls; blob_in stays ready
// whenever that register is empty or being taken in the same cycle
// arst_n clears the parse state and the result valid, and sets the config registers to their defaults
module level_blob_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	lbd_in_if.sink                         blob_in,
	lbd_out_if.source                      res_out,
	input  logic                           cfg_we,
	input  logic [lbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lbd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import lbd_pkg::*;

	cfg_t       cfg;
	blob_stat_t stat;
	res_t       res_n;
	res_t       res_s1;
	logic       out_valid_q;
	logic       take;

	assign blob_in.ready = !out_valid_q || res_out.ready;
	assign take          = blob_in.valid && blob_in.ready;

	lbd_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.idx   (cfg_idx),
		.wdata (cfg_wdata),
		.cfg   (cfg)
	);

	lbd_hdr u_hdr (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.blob_byte(blob_in.blob_byte),
		.is_last  (blob_in.is_last),
		.cfg      (cfg),
		.stat     (stat)
	);

	lbd_judge u_judge (
		.stat     (stat),
		.blob_byte(blob_in.blob_byte),
		.is_last  (blob_in.is_last),
		.cfg      (cfg),
		.res      (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_s1 <= res_n;
	end

	assign res_out.valid         = out_valid_q;
	assign res_out.level_present = res_s1.level_present;
	assign res_out.level         = res_s1.level;
	assign res_out.day_index     = res_s1.day_index;
	assign res_out.done_res      = res_s1.done_res;
	assign res_out.accepted      = res_s1.accepted;
	assign res_out.error_code    = res_s1.error_code;
	assign res_out.start_day     = res_s1.start_day;
	assign res_out.span          = res_s1.span;
	assign res_out.total         = res_s1.total;
	assign res_out.counts_flag   = res_s1.counts_flag;
	assign res_out.filled        = res_s1.filled;

endmodule

[sv/lbd_check.sv]
module lbd_check (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        level_present,
	input logic [7:0]  level,
	input logic [8:0]  day_index,
	input logic        done_res,
	input logic        accepted,
	input logic [2:0]  error_code,
	input logic [31:0] start_day,
	input logic [31:0] total,
	input logic [9:0]  filled
);
	import lbd_pkg::*;

	// a stalled result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(done_res) && $stable(level)
			&& $stable(day_index) && $stable(error_code))
		else $error("result changed while stalled");

	a_verdict_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> !accepted && error_code == ERR_OK)
		else $error("verdict outside the last item");

	a_accept_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> accepted == (error_code == ERR_OK))
		else $error("accepted disagrees with error code");

	a_no_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !level_present |-> level == 8'd0 && day_index == 9'd0)
		else $error("level fields set without a level");

	a_rejected_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> start_day == 32'd0 && total == 32'd0 && filled == 10'd0)
		else $error("decoded fields shown for a rejected blob");

endmodule

bind level_blob_decoder lbd_check u_lbd_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (res_out.valid),
	.out_ready    (res_out.ready),
	.level_present(res_out.level_present),
	.level        (res_out.level),
	.day_index    (res_out.day_index),
	.done_res     (res_out.done_res),
	.accepted     (res_out.accepted),
	.error_code   (res_out.error_code),
	.start_day    (res_out.start_day),
	.total        (res_out.total),
	.filled       (res_out.filled)
);

[bench/testbench.sv]
module testbench;
	import lbd_pkg::*;

	typedef enum {
		BL_GOOD, BL_SHORT, BL_FORMAT, BL_FLAGS, BL_SPAN0, BL_SPANBIG,
		BL_LENGTH, BL_DAY, BL_LEVEL, BL_NOISE
	} blob_kind_t;

	// one row of the directed table; pinned rows carry a hand-written result
	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       pin;
		res_t       want;
	} row_t;

	localparam res_t NO_RES = '0;
	localparam res_t SHORT_RES = '{
		level_present: 1'b0, level: 8'h00, day_index: 9'd0, done_res: 1'b1,
		accepted: 1'b0, error_code: ERR_SHORT, start_day: 32'sd0, span: 10'd0,
		total: 32'h0, counts_flag: 1'b0, filled: 10'd0
	};
	localparam res_t FLAGS_RES = '{
		level_present: 1'b0, level: 8'h00, day_index: 9'd0, done_res: 1'b1,
		accepted: 1'b0, error_code: ERR_FORMAT, start_day: 32'sd0, span: 10'd0,
		total: 32'h0, counts_flag: 1'b0, filled: 10'd0
	};
	localparam res_t GOOD_RES = '{
		level_present: 1'b1, level: 8'h04, day_index: 9'd0, done_res: 1'b1,
		accepted: 1'b1, error_code: ERR_OK, start_day: 32'sd0, span: 10'd1,
		total: 32'hFFFF_FFFF, counts_flag: 1'b1, filled: 10'd1
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	lbd_in_if blob_in ();
	lbd_out_if res_out ();

	level_blob_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.blob_in   (blob_in),
		.res_out   (res_out),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// decoder state as the bench sees it
	cfg_t cfg_m = '{min_day: 32'sd0, max_day: 32'sd0, level_max: 8'd4, unknown_level: 8'd255};
	logic [POS_W-1:0]   pos_q = '0;
	logic [7:0]         fmt_q = '0;
	logic [7:0]         flags_q = '0;
	logic [31:0]        first_q = '0;
	logic [15:0]        span_q = '0;
	logic [31:0]        total_q = '0;
	logic [COUNT_W-1:0] known_q = '0;
	logic               bad_q = 1'b0;

	res_t decoded_q [$];
	row_t dir_tab [26];
	res_t pin_res;
	logic pin_on;
	bit idle_on;
	int unsigned sent_n, results_n, blobs_n, fails;
	int unsigned verdicts [8];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic res_t decode_byte(input logic [7:0] b, input logic last);
		res_t r;
		int unsigned pi, idx;
		longint len, fd, lo, hi, sp;
		logic [2:0] code;
		r = '0;
		pi = pos_q;
		if (pi == 0) fmt_q = b;
		else if (pi == 1) flags_q = b;
		else if (pi <= 5) first_q[8*(pi-2) +: 8] = b;
		else if (pi <= 7) span_q[8*(pi-6) +: 8] = b;
		else if (pi < HEADER_BYTES) total_q[8*(pi-8) +: 8] = b;
		else begin
			idx = pi - HEADER_BYTES;
			if (idx < span_q && idx < MAX_SPAN) begin
				r.level_present = 1'b1;
				r.level = b;
				r.day_index = idx[8:0];
				if (b > cfg_m.level_max && b != cfg_m.unknown_level) bad_q = 1'b1;
				if (b != cfg_m.unknown_level && known_q != COUNT_MAX) known_q++;
			end
		end
		if (pos_q != POS_MAX) pos_q++;
		if (last) begin
			len = pi + 1;
			fd = $signed(first_q);
			lo = $signed(cfg_m.min_day);
			hi = $signed(cfg_m.max_day);
			sp = span_q;
			if (len < HEADER_BYTES) code = ERR_SHORT;
			else if (fmt_q != FORMAT_ONE || (flags_q & ~FLAG_COUNTS) != 0) code = ERR_FORMAT;
			else if (sp == 0 || sp > MAX_SPAN) code = ERR_SPAN;
			else if (len != sp + HEADER_BYTES) code = ERR_LENGTH;
			else if (fd < lo || fd > hi || fd + sp - 1 > hi) code = ERR_DAY;
			else if (bad_q) code = ERR_LEVEL;
			else code = ERR_OK;
			r.done_res = 1'b1;
			r.error_code = code;
			if (code == ERR_OK) begin
				r.accepted = 1'b1;
				r.start_day = first_q;
				r.span = span_q[9:0];
				r.total = total_q;
				r.counts_flag = (flags_q & FLAG_COUNTS) != 0;
				r.filled = known_q;
			end
			pos_q = '0;
			fmt_q = '0;
			flags_q = '0;
			first_q = '0;
			span_q = '0;
			total_q = '0;
			known_q = '0;
			bad_q = 1'b0;
		end
		return r;
	endfunction

	function automatic void chk(input string nm, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			fails++;
			if (fails <= 100) $error("%s: expected %0h, got %0h", nm, want, got);
		end
	endfunction

	always @(posedge clk) begin : mon
		res_t want;
		if (arst_n) begin
			if (res_out.valid && res_out.ready) begin
				if (decoded_q.size() == 0) begin
					fails++;
					if (fails <= 100) $error("result item with nothing pending");
				end else begin
					want = decoded_q.pop_front();
					chk("level_present", want.level_present, res_out.level_present);
					chk("level", want.level, res_out.level);
					chk("day_index", want.day_index, res_out.day_index);
					chk("done_res", want.done_res, res_out.done_res);
					chk("accepted", want.accepted, res_out.accepted);
					chk("error_code", want.error_code, res_out.error_code);
					chk("start_day", want.start_day, res_out.start_day);
					chk("span", want.span, res_out.span);
					chk("total", want.total, res_out.total);
					chk("counts_flag", want.counts_flag, res_out.counts_flag);
					chk("filled", want.filled, res_out.filled);
					results_n++;
					if (want.done_res) begin
						blobs_n++;
						verdicts[want.error_code]++;
					end
				end
			end
			if (blob_in.valid && blob_in.ready) begin
				// predictor always runs so its state stays in step
				want = decode_byte(blob_in.blob_byte, blob_in.is_last);
				if (pin_on) want = pin_res;
				decoded_q.push_back(want);
			end
		end
	end

	always @(negedge clk)
		res_out.ready <= !idle_on || $urandom_range(99) >= 28;

	task automatic put_byte(input logic [7:0] b, input logic last, input logic pin,
			input res_t want);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 28) begin
			blob_in.valid <= 1'b0;
			@(negedge clk);
		end
		blob_in.valid <= 1'b1;
		blob_in.blob_byte <= b;
		blob_in.is_last <= last;
		pin_on <= pin;
		pin_res <= want;
		do @(posedge clk); while (!blob_in.ready);
		sent_n++;
	endtask

	// hold the input off until every pending result has come back
	task automatic settle();
		@(negedge clk);
		blob_in.valid <= 1'b0;
		while (decoded_q.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic load_cfg(input cfg_t c);
		cfg_we <= 1'b1;
		cfg_idx <= REG_MIN_DAY;
		cfg_wdata <= c.min_day;
		@(negedge clk);
		cfg_idx <= REG_MAX_DAY;
		cfg_wdata <= c.max_day;
		@(negedge clk);
		// junk in the upper bits must be dropped
		cfg_idx <= REG_LEVEL_MAX;
		cfg_wdata <= {24'($urandom), c.level_max};
		@(negedge clk);
		cfg_idx <= REG_UNKNOWN;
		cfg_wdata <= {24'($urandom), c.unknown_level};
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_m = c;
	endtask

	task automatic send_blob(input blob_kind_t kind, input int unsigned span_n);
		logic [7:0] bytes_q [$];
		logic [7:0] fmt, flg, lv;
		logic [15:0] sp;
		logic [31:0] tot;
		longint lo, hi, room, fd;
		int unsigned n_lvl, bad_at, cut;
		lo = $signed(cfg_m.min_day);
		hi = $signed(cfg_m.max_day);
		sp = 16'(span_n);
		n_lvl = span_n;
		fmt = FORMAT_ONE;
		flg = $urandom_range(1) ? FLAG_COUNTS : 8'h00;
		tot = $urandom;
		room = hi - lo - longint'(sp) + 2;
		// favor the window edges
		case ($urandom_range(3))
			0: fd = lo;
			1: fd = hi - sp + 1;
			default: fd = (room > 0) ? lo + longint'({$urandom, $urandom} % 64'(room)) : lo;
		endcase
		bad_at = n_lvl;
		case (kind)
			BL_FORMAT: fmt = $urandom_range(1) ? 8'h00 : 8'($urandom_range(2, 255));
			BL_FLAGS: flg = {7'($urandom_range(1, 127)), 1'($urandom)};
			BL_SPAN0: begin
				sp = '0;
				n_lvl = $urandom_range(3);
			end
			BL_SPANBIG: begin
				sp = 16'($urandom_range(MAX_SPAN + 1, 65535));
				n_lvl = $urandom_range(20);
			end
			BL_LENGTH: n_lvl = ($urandom_range(1) || span_n == 0) ?
					span_n + $urandom_range(1, 3) : span_n - 1;
			BL_DAY: begin
				case ($urandom_range(2))
					0: fd = lo - $urandom_range(1, 1000);
					1: fd = hi + $urandom_range(1, 1000);
					default: fd = hi - sp + 1 + $urandom_range(1, 3);
				endcase
			end
			BL_LEVEL: if (cfg_m.level_max != 8'hFF && n_lvl != 0) bad_at = $urandom_range(n_lvl - 1);
			default: ;
		endcase
		bytes_q = {fmt, flg, fd[7:0], fd[15:8], fd[23:16], fd[31:24], sp[7:0], sp[15:8],
			tot[7:0], tot[15:8], tot[23:16], tot[31:24]};
		for (int i = 0; i < n_lvl; i++) begin
			if (i == bad_at) lv = 8'($urandom_range(cfg_m.level_max + 1, 255));
			else if ($urandom_range(3) == 0) lv = cfg_m.unknown_level;
			else if (kind != BL_GOOD && $urandom_range(7) == 0) lv = 8'($urandom);
			else lv = 8'($urandom_range(cfg_m.level_max));
			bytes_q.push_back(lv);
		end
		if (kind == BL_SHORT) begin
			cut = $urandom_range(1, HEADER_BYTES - 1);
			while (bytes_q.size() > cut) void'(bytes_q.pop_back());
		end else if (kind == BL_NOISE) begin
			bytes_q = {};
			repeat ($urandom_range(1, 30)) bytes_q.push_back(8'($urandom));
		end
		foreach (bytes_q[i]) put_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b0, NO_RES);
	endtask

	task automatic run_phase(input cfg_t c, input bit idle, input bit big, input int unsigned upto);
		int unsigned r;
		blob_kind_t kind;
		settle();
		load_cfg(c);
		idle_on = idle;
		if (big) send_blob(BL_GOOD, MAX_SPAN);
		while (sent_n < upto) begin
			r = $urandom_range(99);
			if (r < 55) kind = BL_GOOD;
			else if (r < 60) kind = BL_SHORT;
			else if (r < 65) kind = BL_FORMAT;
			else if (r < 70) kind = BL_FLAGS;
			else if (r < 74) kind = BL_SPAN0;
			else if (r < 78) kind = BL_SPANBIG;
			else if (r < 84) kind = BL_LENGTH;
			else if (r < 90) kind = BL_DAY;
			else if (r < 96) kind = BL_LEVEL;
			else kind = BL_NOISE;
			send_blob(kind, ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 64));
		end
	endtask

	initial begin
		logic [31:0] one_day;
		longint w_lo, w_hi;
		arst_n = 1'b0;
		blob_in.valid = 1'b0;
		blob_in.blob_byte = '0;
		blob_in.is_last = 1'b0;
		res_out.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		pin_on = 1'b0;
		pin_res = NO_RES;
		idle_on = 1'b1;
		dir_tab = '{
			// lone byte: too short
			'{8'h01, 1'b1, 1'b1, SHORT_RES},
			// smallest good blob, total at its maximum
			'{8'h01, 1'b0, 1'b1, NO_RES}, '{8'h01, 1'b0, 1'b1, NO_RES},
			'{8'h00, 1'b0, 1'b1, NO_RES}, '{8'h00, 1'b0, 1'b1, NO_RES},
			'{8'h00, 1'b0, 1'b1, NO_RES}, '{8'h00, 1'b0, 1'b1, NO_RES},
			'{8'h01, 1'b0, 1'b1, NO_RES}, '{8'h00, 1'b0, 1'b1, NO_RES},
			'{8'hFF, 1'b0, 1'b1, NO_RES}, '{8'hFF, 1'b0, 1'b1, NO_RES},
			'{8'hFF, 1'b0, 1'b1, NO_RES}, '{8'hFF, 1'b0, 1'b1, NO_RES},
			'{8'h04, 1'b1, 1'b1, GOOD_RES},
			// reserved flag bits set, most negative first day, widest span
			'{8'h01, 1'b0, 1'b0, NO_RES}, '{8'hFE, 1'b0, 1'b0, NO_RES},
			'{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
			'{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h80, 1'b0, 1'b0, NO_RES},
			'{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES},
			'{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
			'{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b1, 1'b1, FLAGS_RES}
		};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) put_byte(dir_tab[i].b, dir_tab[i].last, dir_tab[i].pin, dir_tab[i].want);

		run_phase('{min_day: -32'sd1000, max_day: 32'sd1000, level_max: 8'd4,
			unknown_level: 8'd255}, 1'b1, 1'b0, 180);
		run_phase('{min_day: 32'sh8000_0000, max_day: 32'sh7FFF_FFFF, level_max: 8'd255,
			unknown_level: 8'd0}, 1'b1, 1'b1, 760);
		one_day = $urandom;
		run_phase('{min_day: one_day, max_day: one_day, level_max: 8'd0,
			unknown_level: 8'($urandom)}, 1'b1, 1'b0, 820);
		// empty window: every well-formed blob fails on its day range
		run_phase('{min_day: 32'sd100, max_day: -32'sd100, level_max: 8'd7,
			unknown_level: 8'h80}, 1'b1, 1'b0, 860);
		w_lo = $signed($urandom);
		w_hi = w_lo + $urandom_range(0, 1 << 20);
		if (w_hi > 64'sd2147483647) w_hi = 64'sd2147483647;
		run_phase('{min_day: w_lo[31:0], max_day: w_hi[31:0], level_max: 8'($urandom),
			unknown_level: 8'($urandom)}, 1'b0, 1'b0, 980);
		run_phase('{min_day: 32'sh7FFF_FDA8, max_day: 32'sh7FFF_FFFF, level_max: 8'd3,
			unknown_level: 8'd3}, 1'b1, 1'b0, 1050);

		settle();
		$display("%0d items in %0d blobs, %0d result items checked, %0d mismatches",
			sent_n, blobs_n, results_n, fails);
		$display("verdicts: ok %0d short %0d format %0d span %0d length %0d day %0d level %0d",
			verdicts[ERR_OK], verdicts[ERR_SHORT], verdicts[ERR_FORMAT], verdicts[ERR_SPAN],
			verdicts[ERR_LENGTH], verdicts[ERR_DAY], verdicts[ERR_LEVEL]);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("timeout, %0d result items still pending", decoded_q.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
sv/lbd_pkg.sv
sv/lbd_if.sv
sv/lbd_cfg.sv
sv/lbd_hdr.sv
sv/lbd_judge.sv
sv/level_blob_decoder.sv
sv/lbd_check.sv
bench/testbench.sv
